/* src/prie_pkg.sv */
// Package: widths, constants, config register indexes and microcode ROM for the PageRank engine.
`timescale 1ns / 1ps
package prie_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 1024;
  localparam int FRAC_BITS    = 16;

  localparam int VTX_W     = $clog2(MAX_VERTICES);
  localparam int EADDR_W   = $clog2(MAX_EDGES);
  localparam int ECNT_W    = EADDR_W + 1;
  localparam int DEG_W     = ECNT_W;
  localparam int RANK_W    = 23;
  localparam int VCNT_W    = 7;
  localparam int ITER_W    = 8;
  localparam int DAMP_W    = 17;
  localparam int PROD_W    = DAMP_W + RANK_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};
  localparam logic [RANK_W-1:0] RANK_ONE = RANK_W'(1) << FRAC_BITS;
  localparam logic [DAMP_W-1:0] DAMP_ONE = DAMP_W'(1) << FRAC_BITS;

  localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(64);
  localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(20);
  localparam logic [DAMP_W-1:0] DAMP_RESET = DAMP_W'(55705);

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING_FACTOR  = 2'd2;

  // microcode: step addresses
  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] S_WAIT      = 5'd0;
  localparam logic [PC_W-1:0] S_STORE     = 5'd1;
  localparam logic [PC_W-1:0] S_DEGWB     = 5'd2;
  localparam logic [PC_W-1:0] S_INIT      = 5'd3;
  localparam logic [PC_W-1:0] S_ZCHK      = 5'd4;
  localparam logic [PC_W-1:0] S_CLR       = 5'd5;
  localparam logic [PC_W-1:0] S_ERD       = 5'd6;
  localparam logic [PC_W-1:0] S_ECHK      = 5'd7;
  localparam logic [PC_W-1:0] S_DIVGO     = 5'd8;
  localparam logic [PC_W-1:0] S_DIVW      = 5'd9;
  localparam logic [PC_W-1:0] S_SUMWB     = 5'd10;
  localparam logic [PC_W-1:0] S_URD       = 5'd11;
  localparam logic [PC_W-1:0] S_UMUL      = 5'd12;
  localparam logic [PC_W-1:0] S_UWB       = 5'd13;
  localparam logic [PC_W-1:0] S_ITER      = 5'd14;
  localparam logic [PC_W-1:0] S_EMIT_RD   = 5'd15;
  localparam logic [PC_W-1:0] S_EMIT_WAIT = 5'd16;
  localparam logic [PC_W-1:0] S_EMIT_LD   = 5'd17;
  localparam logic [PC_W-1:0] S_CLEAR     = 5'd18;

  // microcode: datapath actions
  localparam int ACT_W = 5;
  localparam logic [ACT_W-1:0] A_NONE   = 5'd0;
  localparam logic [ACT_W-1:0] A_ACCEPT = 5'd1;
  localparam logic [ACT_W-1:0] A_STORE  = 5'd2;
  localparam logic [ACT_W-1:0] A_DEGWB  = 5'd3;
  localparam logic [ACT_W-1:0] A_INIT   = 5'd4;
  localparam logic [ACT_W-1:0] A_CLR    = 5'd5;
  localparam logic [ACT_W-1:0] A_ERD    = 5'd6;
  localparam logic [ACT_W-1:0] A_TRD    = 5'd7;
  localparam logic [ACT_W-1:0] A_DIVGO  = 5'd8;
  localparam logic [ACT_W-1:0] A_SUMWB  = 5'd9;
  localparam logic [ACT_W-1:0] A_URD    = 5'd10;
  localparam logic [ACT_W-1:0] A_UMUL   = 5'd11;
  localparam logic [ACT_W-1:0] A_UWB    = 5'd12;
  localparam logic [ACT_W-1:0] A_ITER   = 5'd13;
  localparam logic [ACT_W-1:0] A_EMRD   = 5'd14;
  localparam logic [ACT_W-1:0] A_EMLD   = 5'd15;
  localparam logic [ACT_W-1:0] A_CLEAR  = 5'd16;

  // microcode: jump conditions
  localparam int COND_W = 4;
  localparam logic [COND_W-1:0] C_NEXT       = 4'd0;
  localparam logic [COND_W-1:0] C_ALWAYS     = 4'd1;
  localparam logic [COND_W-1:0] C_NO_INPUT   = 4'd2;
  localparam logic [COND_W-1:0] C_NOT_FINAL  = 4'd3;
  localparam logic [COND_W-1:0] C_VTX_MORE   = 4'd4;
  localparam logic [COND_W-1:0] C_ZERO_ITER  = 4'd5;
  localparam logic [COND_W-1:0] C_EDGES_DONE = 4'd6;
  localparam logic [COND_W-1:0] C_SKIP_EDGE  = 4'd7;
  localparam logic [COND_W-1:0] C_DIV_BUSY   = 4'd8;
  localparam logic [COND_W-1:0] C_ITER_MORE  = 4'd9;
  localparam logic [COND_W-1:0] C_OUT_STALL  = 4'd10;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } uword_t;

  // control store
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      S_WAIT:      w = {A_ACCEPT, C_NO_INPUT,   S_WAIT};
      S_STORE:     w = {A_STORE,  C_NEXT,       S_WAIT};
      S_DEGWB:     w = {A_DEGWB,  C_NOT_FINAL,  S_WAIT};
      S_INIT:      w = {A_INIT,   C_VTX_MORE,   S_INIT};
      S_ZCHK:      w = {A_NONE,   C_ZERO_ITER,  S_EMIT_RD};
      S_CLR:       w = {A_CLR,    C_VTX_MORE,   S_CLR};
      S_ERD:       w = {A_ERD,    C_EDGES_DONE, S_URD};
      S_ECHK:      w = {A_TRD,    C_SKIP_EDGE,  S_ERD};
      S_DIVGO:     w = {A_DIVGO,  C_NEXT,       S_WAIT};
      S_DIVW:      w = {A_NONE,   C_DIV_BUSY,   S_DIVW};
      S_SUMWB:     w = {A_SUMWB,  C_ALWAYS,     S_ERD};
      S_URD:       w = {A_URD,    C_NEXT,       S_WAIT};
      S_UMUL:      w = {A_UMUL,   C_NEXT,       S_WAIT};
      S_UWB:       w = {A_UWB,    C_VTX_MORE,   S_URD};
      S_ITER:      w = {A_ITER,   C_ITER_MORE,  S_CLR};
      S_EMIT_RD:   w = {A_EMRD,   C_NEXT,       S_WAIT};
      S_EMIT_WAIT: w = {A_NONE,   C_OUT_STALL,  S_EMIT_WAIT};
      S_EMIT_LD:   w = {A_EMLD,   C_VTX_MORE,   S_EMIT_RD};
      S_CLEAR:     w = {A_CLEAR,  C_ALWAYS,     S_WAIT};
      default:     w = {A_NONE,   C_ALWAYS,     S_WAIT};
    endcase
    return w;
  endfunction

endpackage

/* src/prie_edge_if.sv */
// Interfaces: edge input channel and rank result channel.
`timescale 1ns / 1ps
interface prie_edge_if;
  logic                        valid;
  logic                        ready;
  logic [prie_pkg::VTX_W-1:0]  source_vertex;
  logic [prie_pkg::VTX_W-1:0]  target_vertex;
  logic                        final_edge;

  modport source (output valid, source_vertex, target_vertex, final_edge, input ready);
  modport sink   (input valid, source_vertex, target_vertex, final_edge, output ready);
endinterface

interface prie_rank_if;
  logic                        valid;
  logic                        ready;
  logic [prie_pkg::VTX_W-1:0]  vertex_index;
  logic [prie_pkg::RANK_W-1:0] rank_value;
  logic                        last_vertex;
  logic                        edges_dropped;

  modport source (output valid, vertex_index, rank_value, last_vertex, edges_dropped,
                  input ready);
  modport sink   (input valid, vertex_index, rank_value, last_vertex, edges_dropped,
                  output ready);
endinterface

/* src/prie_div.sv */
// Restoring divider: rank by out-degree, one quotient bit per cycle.
`timescale 1ns / 1ps
module prie_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [prie_pkg::RANK_W-1:0] dividend,
  input  logic [prie_pkg::DEG_W-1:0]  divisor,
  output logic                        busy,
  output logic [prie_pkg::RANK_W-1:0] quotient
);
  import prie_pkg::*;

  localparam int CNT_W = $clog2(RANK_W + 1);

  logic [RANK_W-1:0] quo_r;
  logic [DEG_W-1:0]  rem_r;
  logic [DEG_W-1:0]  div_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic [DEG_W:0]    trial;
  logic [DEG_W+1:0]  diff;
  logic              ge;

  assign trial = {rem_r, quo_r[RANK_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, div_r};
  assign ge    = ~diff[DEG_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(RANK_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[RANK_W-2:0], ge};
      rem_r <= ge ? diff[DEG_W-1:0] : trial[DEG_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

/* src/pagerank_iteration_engine_top.sv */
// Top level: PageRank power-iteration engine, microcoded sequencer over edge/rank/sum stores.
// Edge load: each edge is accepted, stored, then its source degree written back.
// Compute after the final edge: ranks start at one, then each iteration clears the sums,
//   adds each summed edge's rank share (serial divide by out-degree), then updates ranks.
// Emit: rank read, wait while the sink stalls, result load per vertex; then the store clears.
// Reset (synchronous, rst_n low): sequencer idle, store empty, degrees and drop flag clear.
`timescale 1ns / 1ps
module pagerank_iteration_engine_top (
  input  logic                            clk,
  input  logic                            rst_n,
  prie_edge_if.sink                       in_edge,
  prie_rank_if.source                     out_rank,
  input  logic                            cfg_we,
  input  logic [prie_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prie_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import prie_pkg::*;

  // sequencer
  logic [PC_W-1:0]   pc_r, pc_nxt;
  uword_t            uw;
  logic              jump;

  // config
  logic [VCNT_W-1:0] vc_r;
  logic [ITER_W-1:0] iter_r;
  logic [DAMP_W-1:0] damp_r;
  logic [VCNT_W-1:0] nv;
  logic [DAMP_W-1:0] d_eff;
  logic [DAMP_W-1:0] one_m_d;

  // load path
  logic [VTX_W-1:0]  src_r, dst_r;
  logic              fin_r;
  logic              ok_r, ok_nxt;
  logic              edge_ok;
  logic [ECNT_W-1:0] ecnt_r, ecnt_nxt;
  logic              drop_r, drop_nxt;

  // loop counters
  logic [ECNT_W-1:0] ei_r, ei_nxt;
  logic [VTX_W-1:0]  vi_r, vi_nxt;
  logic [ITER_W-1:0] it_r, it_nxt;
  logic              last_vi;
  logic              in_fire;
  logic              out_stall;
  logic              skip_edge;

  // stores
  logic [2*VTX_W-1:0] edge_mem [MAX_EDGES];
  logic [2*VTX_W-1:0] edge_rd_r;
  logic               edge_we, edge_re;
  logic [VTX_W-1:0]   es, et;

  logic [DEG_W-1:0]        deg_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] deg_vld_r;
  logic [DEG_W-1:0]        deg_rd_r;
  logic                    deg_rv_r;
  logic [DEG_W-1:0]        deg_val;
  logic [VTX_W-1:0]        deg_ra;
  logic                    deg_we, deg_re;

  logic [RANK_W-1:0] rank_mem [MAX_VERTICES];
  logic [RANK_W-1:0] rank_rd_r;
  logic [RANK_W-1:0] rank_wd;
  logic [VTX_W-1:0]  rank_ra;
  logic              rank_we, rank_re;

  logic [RANK_W-1:0] sum_mem [MAX_VERTICES];
  logic [RANK_W-1:0] sum_rd_r;
  logic [RANK_W-1:0] sum_wd;
  logic [VTX_W-1:0]  sum_ra, sum_wa;
  logic              sum_we, sum_re;

  // arithmetic
  logic              div_busy;
  logic [RANK_W-1:0] quo;
  logic [RANK_W:0]   sum_add;
  logic [RANK_W-1:0] sum_sat;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] upd_sum;
  logic [RANK_W-1:0] upd_rank;

  // result register
  logic              out_valid_r;
  logic [VTX_W-1:0]  out_vtx_r;
  logic [RANK_W-1:0] out_rank_r;
  logic              out_last_r;
  logic              out_drop_r;

  // ---------------- config ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r   <= VCNT_RESET;
      iter_r <= ITER_RESET;
      damp_r <= DAMP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERTEX_COUNT:    vc_r   <= cfg_wdata[VCNT_W-1:0];
        CFG_ITERATION_COUNT: iter_r <= cfg_wdata[ITER_W-1:0];
        CFG_DAMPING_FACTOR:  damp_r <= cfg_wdata[DAMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (vc_r == '0) begin
      nv = VCNT_W'(1);
    end else if (vc_r > VCNT_W'(MAX_VERTICES)) begin
      nv = VCNT_W'(MAX_VERTICES);
    end else begin
      nv = vc_r;
    end
  end

  assign d_eff   = (damp_r > DAMP_ONE) ? DAMP_ONE : damp_r;
  assign one_m_d = DAMP_ONE - d_eff;

  // ---------------- sequencer ----------------
  assign uw        = ucode(pc_r);
  assign in_fire   = in_edge.valid && in_edge.ready;
  assign out_stall = out_valid_r && !out_rank.ready;
  assign last_vi   = (VCNT_W'(vi_r) == (nv - VCNT_W'(1)));
  assign es        = edge_rd_r[2*VTX_W-1:VTX_W];
  assign et        = edge_rd_r[VTX_W-1:0];
  assign skip_edge = (VCNT_W'(es) >= nv) || (VCNT_W'(et) >= nv);
  assign edge_ok   = (VCNT_W'(src_r) < nv) && (VCNT_W'(dst_r) < nv) &&
                     (ecnt_r < ECNT_W'(MAX_EDGES));

  always_comb begin
    case (uw.cond)
      C_NEXT:       jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_NO_INPUT:   jump = !in_fire;
      C_NOT_FINAL:  jump = !fin_r;
      C_VTX_MORE:   jump = !last_vi;
      C_ZERO_ITER:  jump = (iter_r == '0);
      C_EDGES_DONE: jump = (ei_r == ecnt_r);
      C_SKIP_EDGE:  jump = skip_edge;
      C_DIV_BUSY:   jump = div_busy;
      C_ITER_MORE:  jump = (({1'b0, it_r} + 9'd1) != {1'b0, iter_r});
      C_OUT_STALL:  jump = out_stall;
      default:      jump = 1'b1;
    endcase
  end

  always_comb begin
    pc_nxt   = jump ? uw.target : pc_r + PC_W'(1);
    ok_nxt   = ok_r;
    ecnt_nxt = ecnt_r;
    drop_nxt = drop_r;
    ei_nxt   = ei_r;
    vi_nxt   = vi_r;
    it_nxt   = it_r;

    case (uw.act)
      A_STORE: begin
        ok_nxt = edge_ok;
        if (edge_ok) begin
          ecnt_nxt = ecnt_r + ECNT_W'(1);
        end else begin
          drop_nxt = 1'b1;
        end
      end
      A_INIT: begin
        it_nxt = '0;
        vi_nxt = last_vi ? '0 : vi_r + VTX_W'(1);
      end
      A_CLR: begin
        ei_nxt = '0;
        vi_nxt = last_vi ? '0 : vi_r + VTX_W'(1);
      end
      A_ERD:   ei_nxt = ei_r + ECNT_W'(1);
      A_UWB:   vi_nxt = last_vi ? '0 : vi_r + VTX_W'(1);
      A_EMLD:  vi_nxt = last_vi ? '0 : vi_r + VTX_W'(1);
      A_ITER:  it_nxt = it_r + ITER_W'(1);
      A_CLEAR: begin
        ecnt_nxt = '0;
        drop_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= S_WAIT;
      ok_r        <= 1'b0;
      ecnt_r      <= '0;
      drop_r      <= 1'b0;
      ei_r        <= '0;
      vi_r        <= '0;
      it_r        <= '0;
      deg_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      ok_r   <= ok_nxt;
      ecnt_r <= ecnt_nxt;
      drop_r <= drop_nxt;
      ei_r   <= ei_nxt;
      vi_r   <= vi_nxt;
      it_r   <= it_nxt;
      if (uw.act == A_CLEAR) begin
        deg_vld_r <= '0;
      end else if (deg_we) begin
        deg_vld_r[src_r] <= 1'b1;
      end
      if (uw.act == A_EMLD) begin
        out_valid_r <= 1'b1;
      end else if (out_rank.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // edge capture and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      src_r <= in_edge.source_vertex;
      dst_r <= in_edge.target_vertex;
      fin_r <= in_edge.final_edge;
    end
    if (uw.act == A_EMLD) begin
      out_vtx_r  <= vi_r;
      out_rank_r <= rank_rd_r;
      out_last_r <= last_vi;
      out_drop_r <= drop_r;
    end
  end

  // ---------------- edge store ----------------
  assign edge_we = (uw.act == A_STORE) && edge_ok;
  assign edge_re = (uw.act == A_ERD);

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[ecnt_r[EADDR_W-1:0]] <= {src_r, dst_r};
    end
    if (edge_re) begin
      edge_rd_r <= edge_mem[ei_r[EADDR_W-1:0]];
    end
  end

  // ---------------- degree table ----------------
  assign deg_re  = (uw.act == A_STORE) || (uw.act == A_TRD);
  assign deg_ra  = (uw.act == A_STORE) ? src_r : es;
  assign deg_we  = (uw.act == A_DEGWB) && ok_r;
  assign deg_val = deg_rv_r ? deg_rd_r : '0;

  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[src_r] <= deg_val + DEG_W'(1);
    end
    if (deg_re) begin
      deg_rd_r <= deg_mem[deg_ra];
      deg_rv_r <= deg_vld_r[deg_ra];
    end
  end

  // ---------------- rank table ----------------
  assign rank_re = (uw.act == A_TRD) || (uw.act == A_EMRD);
  assign rank_ra = (uw.act == A_TRD) ? es : vi_r;
  assign rank_we = (uw.act == A_INIT) || (uw.act == A_UWB);
  assign rank_wd = (uw.act == A_INIT) ? RANK_ONE : upd_rank;

  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[vi_r] <= rank_wd;
    end
    if (rank_re) begin
      rank_rd_r <= rank_mem[rank_ra];
    end
  end

  // ---------------- sum table ----------------
  assign sum_re = (uw.act == A_TRD) || (uw.act == A_URD);
  assign sum_ra = (uw.act == A_TRD) ? et : vi_r;
  assign sum_we = (uw.act == A_CLR) || (uw.act == A_SUMWB);
  assign sum_wa = (uw.act == A_SUMWB) ? et : vi_r;
  assign sum_wd = (uw.act == A_SUMWB) ? sum_sat : '0;

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_wa] <= sum_wd;
    end
    if (sum_re) begin
      sum_rd_r <= sum_mem[sum_ra];
    end
  end

  // ---------------- arithmetic ----------------
  prie_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (uw.act == A_DIVGO),
    .dividend (rank_rd_r),
    .divisor  (deg_val),
    .busy     (div_busy),
    .quotient (quo)
  );

  assign sum_add = {1'b0, sum_rd_r} + {1'b0, quo};
  assign sum_sat = sum_add[RANK_W] ? RANK_MAX : sum_add[RANK_W-1:0];

  always_ff @(posedge clk) begin
    if (uw.act == A_UMUL) begin
      prod_r <= d_eff * sum_rd_r;
    end
  end

  assign upd_sum  = PROD_W'(one_m_d) + (prod_r >> FRAC_BITS);
  assign upd_rank = (upd_sum > PROD_W'(RANK_MAX)) ? RANK_MAX : upd_sum[RANK_W-1:0];

  // ---------------- ports ----------------
  assign in_edge.ready          = (uw.act == A_ACCEPT);
  assign out_rank.valid         = out_valid_r;
  assign out_rank.vertex_index  = out_vtx_r;
  assign out_rank.rank_value    = out_rank_r;
  assign out_rank.last_vertex   = out_last_r;
  assign out_rank.edges_dropped = out_drop_r;

endmodule

/* src/prie_checker.sv */
// Checker: port-level assertions for the PageRank engine, bound to the top level.
`timescale 1ns / 1ps
module prie_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_final,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_last,
  input logic [prie_pkg::VTX_W-1:0]  out_vertex,
  input logic [prie_pkg::RANK_W-1:0] out_rank_val
);
  import prie_pkg::*;

  // no results right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vertex) && $stable(out_rank_val))
    else $error("stalled result changed");

  // no new edges while a graph's ranks are still being emitted
  a_no_load_mid_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("edge input open during rank emission");

  // the final edge starts compute, so the input does not reopen right after it
  a_final_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_final |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("edge input reopened after final edge");

endmodule

bind pagerank_iteration_engine_top prie_checker u_prie_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_edge.valid),
  .in_ready     (in_edge.ready),
  .in_final     (in_edge.final_edge),
  .out_valid    (out_rank.valid),
  .out_ready    (out_rank.ready),
  .out_last     (out_rank.last_vertex),
  .out_vertex   (out_rank.vertex_index),
  .out_rank_val (out_rank.rank_value)
);

/* bench/pagerank_iteration_engine_top_test.sv */
// Self-checking testbench for the PageRank engine: directed table, extreme graphs, random graphs.
`timescale 1ns / 1ps
module pagerank_iteration_engine_top_test;
  import prie_pkg::*;

  localparam int                    SETTLE_CYCLES = 8;
  localparam int                    PLAN_ROWS     = 30;
  localparam logic [CFG_IDX_W-1:0]  CFG_UNUSED_INDEX = 2'd3;
  localparam logic [63:0]           UNITY         = 64'(1) << FRAC_BITS;

  typedef enum logic {EDGE_ROW, REG_ROW} row_kind_t;

  // EDGE_ROW: a = source, b = target. REG_ROW: a = write data, b = register index.
  typedef struct packed {
    row_kind_t         kind;
    logic [16:0]       a;
    logic [5:0]        b;
    logic              fin;
    logic              typed;
    logic [RANK_W-1:0] t_rank;
    logic              t_drop;
  } plan_row_t;

  typedef struct packed {
    logic [VTX_W-1:0]  vertex_index;
    logic [RANK_W-1:0] rank_value;
    logic              last_vertex;
    logic              edges_dropped;
  } rank_item_t;

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{REG_ROW,  17'd0,      6'(CFG_ITERATION_COUNT), 1'b0, 1'b0, 23'd0,    1'b0},
    '{EDGE_ROW, 17'd63,     6'd63,                   1'b1, 1'b1, RANK_ONE, 1'b0},
    '{REG_ROW,  17'd0,      6'(CFG_VERTEX_COUNT),    1'b0, 1'b0, 23'd0,    1'b0},
    '{EDGE_ROW, 17'd0,      6'd0,                    1'b0, 1'b0, 23'd0,    1'b0},
    '{EDGE_ROW, 17'd1,      6'd0,                    1'b0, 1'b0, 23'd0,    1'b0},
    '{EDGE_ROW, 17'd0,      6'd2,                    1'b1, 1'b1, RANK_ONE, 1'b1},
    '{REG_ROW,  17'd127,    6'(CFG_VERTEX_COUNT),    1'b0, 1'b0, 23'd0,    1'b0},
    '{REG_ROW,  17'd131071, 6'(CFG_DAMPING_FACTOR),  1'b0, 1'b0, 23'd0,    1'b0},
    '{REG_ROW,  17'd255,    6'(CFG_ITERATION_COUNT), 1'b0, 1'b0, 23'd0,    1'b0},
    '{EDGE_ROW, 17'd0,      6'd1,                    1'b0, 1'b0, 23'd0,    1'b0},
    '{EDGE_ROW, 17'd1,      6'd0,                    1'b1, 1'b0, 23'd0,    1'b0},
    '{REG_ROW,  17'd0,      6'(CFG_DAMPING_FACTOR),  1'b0, 1'b0, 23'd0,    1'b0},
    '{REG_ROW,  17'd3,      6'(CFG_ITERATION_COUNT), 1'b0, 1'b0, 23'd0,    1'b0},
    '{EDGE_ROW, 17'd5,      6'd6,                    1'b0, 1'b0, 23'd0,    1'b0},
    '{EDGE_ROW, 17'd6,      6'd5,                    1'b1, 1'b1, RANK_ONE, 1'b0},
    '{REG_ROW,  17'd131071, 6'(CFG_UNUSED_INDEX),    1'b0, 1'b0, 23'd0,    1'b0},
    '{REG_ROW,  17'd8,      6'(CFG_VERTEX_COUNT),    1'b0, 1'b0, 23'd0,    1'b0},
    '{REG_ROW,  17'd5,      6'(CFG_ITERATION_COUNT), 1'b0, 1'b0, 23'd0,    1'b0},
    '{REG_ROW,  17'd55705,  6'(CFG_DAMPING_FACTOR),  1'b0, 1'b0, 23'd0,    1'b0},
    '{EDGE_ROW, 17'd7,      6'd0,                    1'b0, 1'b0, 23'd0,    1'b0},
    '{EDGE_ROW, 17'd8,      6'd1,                    1'b0, 1'b0, 23'd0,    1'b0},
    '{EDGE_ROW, 17'd0,      6'd8,                    1'b0, 1'b0, 23'd0,    1'b0},
    '{EDGE_ROW, 17'd3,      6'd3,                    1'b0, 1'b0, 23'd0,    1'b0},
    '{EDGE_ROW, 17'd2,      6'd7,                    1'b1, 1'b0, 23'd0,    1'b0},
    // shrink the vertex count between edges of one graph
    '{REG_ROW,  17'd64,     6'(CFG_VERTEX_COUNT),    1'b0, 1'b0, 23'd0,    1'b0},
    '{EDGE_ROW, 17'd10,     6'd20,                   1'b0, 1'b0, 23'd0,    1'b0},
    '{EDGE_ROW, 17'd40,     6'd1,                    1'b0, 1'b0, 23'd0,    1'b0},
    '{REG_ROW,  17'd16,     6'(CFG_VERTEX_COUNT),    1'b0, 1'b0, 23'd0,    1'b0},
    '{EDGE_ROW, 17'd10,     6'd3,                    1'b0, 1'b0, 23'd0,    1'b0},
    '{EDGE_ROW, 17'd15,     6'd10,                   1'b1, 1'b0, 23'd0,    1'b0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  prie_edge_if edge_ch ();
  prie_rank_if rank_ch ();

  pagerank_iteration_engine_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_edge   (edge_ch),
    .out_rank  (rank_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // graph model state
  logic [VTX_W-1:0]  edge_src [MAX_EDGES];
  logic [VTX_W-1:0]  edge_dst [MAX_EDGES];
  int                edges_held = 0;
  logic [63:0]       out_deg  [MAX_VERTICES];
  logic [63:0]       rank_tab [MAX_VERTICES];
  logic [63:0]       sum_tab  [MAX_VERTICES];
  logic              edge_lost = 1'b0;
  logic [VCNT_W-1:0] vcnt_reg  = VCNT_RESET;
  logic [ITER_W-1:0] iter_reg  = ITER_RESET;
  logic [DAMP_W-1:0] damp_reg  = DAMP_RESET;

  rank_item_t ranks_due [$];
  int         mismatch_count = 0;
  int         sender_idle_pct = 0;
  int         receiver_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("** pagerank_iteration_engine_top: FAILED **");
    $finish;
  end

  function automatic int live_count();
    if (vcnt_reg == 0) return 1;
    if (vcnt_reg > MAX_VERTICES) return MAX_VERTICES;
    return int'(vcnt_reg);
  endfunction

  // Store one edge; on the final edge run the power iterations and queue one rank per vertex.
  function automatic void fold_edge(input logic [VTX_W-1:0] sv, input logic [VTX_W-1:0] tv,
                                    input logic fin, input logic typed,
                                    input logic [RANK_W-1:0] typed_rank, input logic typed_drop);
    int          nv;
    logic [63:0] damp;
    logic [63:0] share;
    rank_item_t  r;
    nv = live_count();
    if (sv >= nv || tv >= nv || edges_held >= MAX_EDGES) begin
      edge_lost = 1'b1;
    end else begin
      edge_src[edges_held] = sv;
      edge_dst[edges_held] = tv;
      edges_held++;
      out_deg[sv] = out_deg[sv] + 1;
    end
    if (!fin) return;
    damp = (damp_reg > DAMP_ONE) ? UNITY : 64'(damp_reg);
    for (int i = 0; i < nv; i++) rank_tab[i] = UNITY;
    for (int it = 0; it < int'(iter_reg); it++) begin
      for (int i = 0; i < nv; i++) sum_tab[i] = '0;
      for (int e = 0; e < edges_held; e++) begin
        // edges beyond the current vertex count still hold their degree but add nothing
        if (edge_src[e] < nv && edge_dst[e] < nv && out_deg[edge_src[e]] != 0) begin
          share = rank_tab[edge_src[e]] / out_deg[edge_src[e]];
          sum_tab[edge_dst[e]] = sum_tab[edge_dst[e]] + share;
          if (sum_tab[edge_dst[e]] > RANK_MAX) sum_tab[edge_dst[e]] = 64'(RANK_MAX);
        end
      end
      for (int i = 0; i < nv; i++) begin
        rank_tab[i] = (UNITY - damp) + ((damp * sum_tab[i]) >> FRAC_BITS);
        if (rank_tab[i] > RANK_MAX) rank_tab[i] = 64'(RANK_MAX);
      end
    end
    for (int i = 0; i < nv; i++) begin
      r.vertex_index  = VTX_W'(i);
      r.rank_value    = typed ? typed_rank : rank_tab[i][RANK_W-1:0];
      r.last_vertex   = (i == nv - 1);
      r.edges_dropped = typed ? typed_drop : edge_lost;
      ranks_due.push_back(r);
    end
    edges_held = 0;
    for (int i = 0; i < MAX_VERTICES; i++) out_deg[i] = '0;
    edge_lost = 1'b0;
  endfunction

  task automatic send_edge(input logic [VTX_W-1:0] sv, input logic [VTX_W-1:0] tv,
                           input logic fin, input logic typed,
                           input logic [RANK_W-1:0] typed_rank, input logic typed_drop);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      edge_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    edge_ch.valid         <= 1'b1;
    edge_ch.source_vertex <= sv;
    edge_ch.target_vertex <= tv;
    edge_ch.final_edge    <= fin;
    do @(posedge clk); while (!edge_ch.ready);
    fold_edge(sv, tv, fin, typed, typed_rank, typed_drop);
  endtask

  // Registers change only with the engine idle: all ranks back, plus a settling margin.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    edge_ch.valid <= 1'b0;
    while (ranks_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_VERTEX_COUNT:    vcnt_reg = data[VCNT_W-1:0];
      CFG_ITERATION_COUNT: iter_reg = data[ITER_W-1:0];
      CFG_DAMPING_FACTOR:  damp_reg = data[DAMP_W-1:0];
      default: ;
    endcase
  endtask

  // result sink: random stall, compare every transaction against the oldest expected rank
  initial begin
    rank_item_t got;
    rank_item_t want;
    rank_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rank_ch.valid && rank_ch.ready) begin
        got = '{rank_ch.vertex_index, rank_ch.rank_value, rank_ch.last_vertex,
                rank_ch.edges_dropped};
        if (ranks_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected rank: vertex %0d rank %0d last %0b dropped %0b",
                     got.vertex_index, got.rank_value, got.last_vertex, got.edges_dropped);
        end else begin
          want = ranks_due.pop_front();
          if (got.vertex_index !== want.vertex_index || got.rank_value !== want.rank_value ||
              got.last_vertex !== want.last_vertex ||
              got.edges_dropped !== want.edges_dropped) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("rank mismatch: got vertex %0d rank %0d last %0b dropped %0b, %s %0d %0d %0b %0b",
                       got.vertex_index, got.rank_value, got.last_vertex, got.edges_dropped,
                       "expected", want.vertex_index, want.rank_value, want.last_vertex,
                       want.edges_dropped);
          end
        end
      end
      rank_ch.ready <= rst_n && ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  initial begin
    int               roll;
    int               nv;
    int               ne;
    int               sent;
    logic             big;
    logic [VTX_W-1:0] sv;
    logic [VTX_W-1:0] tv;
    logic [16:0]      vc_pick;
    logic [16:0]      it_pick;
    logic [16:0]      dm_pick;

    for (int i = 0; i < MAX_VERTICES; i++) out_deg[i] = '0;
    rst_n                 <= 1'b0;
    edge_ch.valid         <= 1'b0;
    edge_ch.source_vertex <= '0;
    edge_ch.target_vertex <= '0;
    edge_ch.final_edge    <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= '0;
    cfg_wdata             <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (PLAN[r].kind == REG_ROW)
        write_reg(PLAN[r].b[CFG_IDX_W-1:0], PLAN[r].a);
      else
        send_edge(PLAN[r].a[VTX_W-1:0], PLAN[r].b, PLAN[r].fin, PLAN[r].typed,
                  PLAN[r].t_rank, PLAN[r].t_drop);
    end

    // all rank funneled into vertex 0 with full damping: largest reachable rank
    write_reg(CFG_VERTEX_COUNT, 17'd64);
    write_reg(CFG_DAMPING_FACTOR, 17'(DAMP_ONE));
    write_reg(CFG_ITERATION_COUNT, 17'd1);
    for (int v = 0; v < MAX_VERTICES; v++)
      send_edge(VTX_W'(v), '0, v == MAX_VERTICES - 1, 1'b0, '0, 1'b0);

    // fill the edge store past capacity; the final edge itself is dropped
    write_reg(CFG_VERTEX_COUNT, 17'd4);
    for (int k = 0; k < MAX_EDGES + 6; k++)
      send_edge(VTX_W'($urandom_range(3)), VTX_W'($urandom_range(3)), k == MAX_EDGES + 5,
                1'b0, '0, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 81; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 81; end
        default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
      endcase
      sent = 0;
      while (sent < 58) begin
        if ($urandom_range(1) == 0) begin
          roll    = $urandom_range(19);
          big     = (roll == 0);
          it_pick = big ? 17'($urandom_range(255, 200)) :
                    (roll < 3) ? 17'd0 : 17'($urandom_range(24, 1));
          roll    = $urandom_range(19);
          if (big)           vc_pick = 17'($urandom_range(8, 1));
          else if (roll < 2) vc_pick = 17'd0;
          else if (roll < 4) vc_pick = 17'd64;
          else if (roll < 5) vc_pick = 17'($urandom_range(127, 65));
          else               vc_pick = 17'($urandom_range(64, 1));
          roll = $urandom_range(19);
          if (roll < 2)      dm_pick = 17'd0;
          else if (roll < 4) dm_pick = 17'(DAMP_ONE);
          else if (roll < 5) dm_pick = 17'($urandom_range(131071, 65537));
          else               dm_pick = 17'($urandom_range(65536));
          write_reg(CFG_ITERATION_COUNT, it_pick);
          write_reg(CFG_VERTEX_COUNT, vc_pick);
          write_reg(CFG_DAMPING_FACTOR, dm_pick);
        end
        big = (iter_reg >= 200);
        ne  = big ? $urandom_range(4, 1) : $urandom_range(12, 1);
        for (int k = 0; k < ne; k++) begin
          if (!big && k > 0 && $urandom_range(14) == 0)
            write_reg(CFG_VERTEX_COUNT, 17'($urandom_range(64, 1)));
          nv = live_count();
          if ($urandom_range(9) == 0) begin
            sv = VTX_W'($urandom_range(63));
            tv = VTX_W'($urandom_range(63));
          end else begin
            sv = VTX_W'($urandom_range(nv - 1));
            tv = VTX_W'($urandom_range(nv - 1));
          end
          send_edge(sv, tv, k == ne - 1, 1'b0, '0, 1'b0);
          sent++;
        end
      end
    end

    edge_ch.valid <= 1'b0;
    while (ranks_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("** pagerank_iteration_engine_top: PASSED **");
    else
      $display("** pagerank_iteration_engine_top: FAILED **");
    $finish;
  end

endmodule
